[src/boundary_face_flux_max_assert.svh]
// ----------------------------------------------------------------------------
// Boundary face flux assertion macros
// Shared property forms for the flux block. Each use expands to one labeled
// concurrent assertion clocked on the rising edge and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BOUNDARY_FACE_FLUX_MAX_ASSERT_SVH
`define BOUNDARY_FACE_FLUX_MAX_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BFFM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BFFM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/bffm_pkg.sv]
// ----------------------------------------------------------------------------
// Boundary face flux package
// Item types and fixed-point limits shared by the channels and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bffm_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned DepthW = 24;
  localparam int unsigned VelW   = 16;
  localparam int unsigned FluxW  = 48;
  localparam int unsigned MaxW   = 47;
  localparam int unsigned QW     = 54;

  localparam logic [QW-1:0] FluxPosMax = QW'(48'h7FFF_FFFF_FFFF);
  localparam logic [QW-1:0] FluxNegMag = QW'(48'h8000_0000_0000);

  typedef struct packed {
    logic signed [CoordW-1:0] corner_a_x;
    logic signed [CoordW-1:0] corner_a_y;
    logic signed [CoordW-1:0] corner_b_x;
    logic signed [CoordW-1:0] corner_b_y;
    logic signed [DepthW-1:0] depth_upper;
    logic signed [DepthW-1:0] depth_lower;
    logic signed [VelW-1:0]   normal_velocity;
    logic                     points_outward;
    logic                     pass_start;
  } bffm_in_t;

  typedef struct packed {
    logic signed [FluxW-1:0] face_flux;
    logic        [MaxW-1:0]  max_inward_flux;
  } bffm_out_t;

endpackage

`default_nettype wire

[src/bffm_in_if.sv]
// ----------------------------------------------------------------------------
// Boundary face input channel
// Valid/ready channel that carries one boundary face item.
// ----------------------------------------------------------------------------
`default_nettype none

interface bffm_in_if;
  logic              valid;
  logic              ready;
  bffm_pkg::bffm_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[src/bffm_out_if.sv]
// ----------------------------------------------------------------------------
// Boundary face result channel
// Valid/ready channel that carries one flux result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface bffm_out_if;
  logic               valid;
  logic               ready;
  bffm_pkg::bffm_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[src/boundary_face_flux_max.sv]
// ----------------------------------------------------------------------------
// Boundary face flux with running maximum
// Computes face length by a bit-serial square root, scales it by layer
// thickness, velocity and sign, saturates, and tracks the largest inward flux.
// ----------------------------------------------------------------------------
//
//  Channel    Direction  Handshake        Contents
//  in_chan    sink       valid / ready    corners, depths, velocity, flags
//  out_chan   source     valid / ready    face flux, running maximum
//
//  An item passes from acceptance to its result register through the magnitude
//  state, two multiplier passes for the squares, 33 square root steps, three
//  multiplier passes for the scaling, a saturation state and the max update.
//  The 32x32 multiplier and the square root step are each used once per cycle.
//  A new item is taken only in the idle state; a finished result waits in the
//  done state while the previous one is still held on out_chan.
//  Reset is synchronous and clears the sequencer, the result valid and the max.
// ----------------------------------------------------------------------------
`default_nettype none

`include "boundary_face_flux_max_assert.svh"

module boundary_face_flux_max (
  input  wire           clk,
  input  wire           rst_n,
  bffm_in_if.sink       in_chan,
  bffm_out_if.source    out_chan
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_ABS  = 4'd1;
  localparam logic [3:0] ST_SQX  = 4'd2;
  localparam logic [3:0] ST_SQY  = 4'd3;
  localparam logic [3:0] ST_SQRT = 4'd4;
  localparam logic [3:0] ST_AREA = 4'd5;
  localparam logic [3:0] ST_PLO  = 4'd6;
  localparam logic [3:0] ST_PHI  = 4'd7;
  localparam logic [3:0] ST_SAT  = 4'd8;
  localparam logic [3:0] ST_DONE = 4'd9;

  logic [3:0]  state_r, state_nxt;
  logic [5:0]  cnt_r;
  logic [32:0] dx_r, dy_r;
  logic [24:0] thick_r;
  logic [15:0] vel_r;
  logic        neg_r, start_r;
  logic [31:0] mx_r, my_r;
  logic [24:0] tm_r;
  logic [15:0] vm_r;
  logic [65:0] acc_r;
  logic [34:0] rem_r;
  logic [32:0] root_r;
  logic [57:0] area_r;
  logic [27:0] plo_r;
  logic [bffm_pkg::QW-1:0]    q_r;
  logic [bffm_pkg::FluxW-1:0] flux_r;
  logic        pos_r;
  logic [bffm_pkg::MaxW-1:0]  max_r, max_nxt, max_base;
  logic        out_valid_r;
  bffm_pkg::bffm_out_t out_data_r;

  logic        accept, load_out;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [32:0] dx_abs, dy_abs;
  logic [24:0] thick_abs;
  logic [15:0] vel_abs;
  logic [36:0] rem_t, trial, rem_diff;
  logic        rem_ge;
  logic [bffm_pkg::QW-1:0]    q_sat;
  logic [bffm_pkg::FluxW-1:0] flux_calc;

  assign in_chan.ready  = (state_r == ST_IDLE);
  assign accept         = in_chan.valid && in_chan.ready;
  assign load_out       = (state_r == ST_DONE) && (!out_valid_r || out_chan.ready);
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  assign dx_abs    = dx_r[32] ? (~dx_r + 33'd1) : dx_r;
  assign dy_abs    = dy_r[32] ? (~dy_r + 33'd1) : dy_r;
  assign thick_abs = thick_r[24] ? (~thick_r + 25'd1) : thick_r;
  assign vel_abs   = vel_r[15] ? (~vel_r + 16'd1) : vel_r;

  always_comb begin
    unique case (state_r)
      ST_SQX: begin
        mul_a = mx_r;
        mul_b = mx_r;
      end
      ST_SQY: begin
        mul_a = my_r;
        mul_b = my_r;
      end
      ST_AREA: begin
        mul_a = root_r[31:0];
        mul_b = {7'd0, tm_r};
      end
      ST_PLO: begin
        mul_a = area_r[31:0];
        mul_b = {16'd0, vm_r};
      end
      ST_PHI: begin
        mul_a = {6'd0, area_r[57:32]};
        mul_b = {16'd0, vm_r};
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  assign rem_t    = {rem_r, acc_r[65:64]};
  assign trial    = {2'b00, root_r, 2'b01};
  assign rem_ge   = (rem_t >= trial);
  assign rem_diff = rem_t - trial;

  always_comb begin
    if (neg_r) begin
      q_sat     = (q_r > bffm_pkg::FluxNegMag) ? bffm_pkg::FluxNegMag : q_r;
      flux_calc = ~q_sat[bffm_pkg::FluxW-1:0] + 48'd1;
    end else begin
      q_sat     = (q_r > bffm_pkg::FluxPosMax) ? bffm_pkg::FluxPosMax : q_r;
      flux_calc = q_sat[bffm_pkg::FluxW-1:0];
    end
  end

  assign max_base = start_r ? '0 : max_r;
  assign max_nxt  = (pos_r && (flux_r[bffm_pkg::MaxW-1:0] > max_base)) ?
                    flux_r[bffm_pkg::MaxW-1:0] : max_base;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_ABS;
      ST_ABS:  state_nxt = ST_SQX;
      ST_SQX:  state_nxt = ST_SQY;
      ST_SQY:  state_nxt = ST_SQRT;
      ST_SQRT: if (cnt_r == 6'd0) state_nxt = ST_AREA;
      ST_AREA: state_nxt = ST_PLO;
      ST_PLO:  state_nxt = ST_PHI;
      ST_PHI:  state_nxt = ST_SAT;
      ST_SAT:  state_nxt = ST_DONE;
      ST_DONE: if (load_out) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      max_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
        max_r       <= max_nxt;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dx_r    <= {in_chan.data.corner_b_x[31], in_chan.data.corner_b_x}
               - {in_chan.data.corner_a_x[31], in_chan.data.corner_a_x};
      dy_r    <= {in_chan.data.corner_b_y[31], in_chan.data.corner_b_y}
               - {in_chan.data.corner_a_y[31], in_chan.data.corner_a_y};
      thick_r <= {in_chan.data.depth_upper[23], in_chan.data.depth_upper}
               - {in_chan.data.depth_lower[23], in_chan.data.depth_lower};
      vel_r   <= in_chan.data.normal_velocity;
      neg_r   <= in_chan.data.points_outward ^ in_chan.data.normal_velocity[15]
               ^ (in_chan.data.depth_upper < in_chan.data.depth_lower);
      start_r <= in_chan.data.pass_start;
    end
    unique case (state_r)
      ST_ABS: begin
        mx_r <= dx_abs[31:0];
        my_r <= dy_abs[31:0];
        tm_r <= thick_abs;
        vm_r <= vel_abs;
      end
      ST_SQX: acc_r <= {2'b00, prod};
      ST_SQY: begin
        acc_r  <= acc_r + {2'b00, prod};
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= 6'd32;
      end
      ST_SQRT: begin
        rem_r  <= rem_ge ? rem_diff[34:0] : rem_t[34:0];
        root_r <= {root_r[31:0], rem_ge};
        acc_r  <= {acc_r[63:0], 2'b00};
        cnt_r  <= cnt_r - 6'd1;
      end
      ST_AREA: area_r <= prod[57:0] + (root_r[32] ? {1'b0, tm_r, 32'd0} : 58'd0);
      ST_PLO:  plo_r <= prod[47:20];
      ST_PHI:  q_r <= {prod[41:0], 12'd0} + {26'd0, plo_r};
      ST_SAT: begin
        flux_r <= (q_r == '0) ? '0 : flux_calc;
        pos_r  <= (q_r != '0) && !neg_r;
      end
      ST_DONE: begin
        if (load_out) begin
          out_data_r.face_flux       <= flux_r;
          out_data_r.max_inward_flux <= max_nxt;
        end
      end
      default: begin
      end
    endcase
  end

  `BFFM_ASSERT_NEXT(a_accept_starts, clk, rst_n, accept, state_r == ST_ABS, "Accepted item did not start work.")
  `BFFM_ASSERT_NEXT(a_sqrt_ends, clk, rst_n, (state_r == ST_SQRT) && (cnt_r == 6'd0), state_r == ST_AREA, "Square root did not end after its last step.")
  `BFFM_ASSERT_SAME(a_rem_bound, clk, rst_n, state_r == ST_SQRT, rem_r[34] == 1'b0, "Square root remainder overflowed.")
  `BFFM_ASSERT_NEXT(a_max_monotone, clk, rst_n, load_out && !start_r, max_r >= $past(max_r), "Running maximum decreased within a pass.")
  `BFFM_ASSERT_NEXT(a_max_covers_flux, clk, rst_n, load_out && pos_r, out_data_r.max_inward_flux >= out_data_r.face_flux[46:0], "Running maximum is below a positive flux.")

endmodule

`default_nettype wire
